/* design/sfp_pkg.sv */
// ----------------------------------------------------------------------------
// sfp_pkg
// shared types of the sensor frame parser: configuration set and result word
// ----------------------------------------------------------------------------
package sfp_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] RegHeading   = 3'd0;
  localparam logic [2:0] RegDataFlag  = 3'd1;
  localparam logic [2:0] RegRegFlag   = 3'd2;
  localparam logic [2:0] RegCodes     = 3'd3;
  localparam logic [2:0] RegSlotEn    = 3'd4;

  localparam int unsigned NumSlots = 7;

  // reset values of the configuration registers
  localparam logic [7:0] HeadingReset  = 8'h55;
  localparam logic [7:0] DataFlagReset = 8'h61;
  localparam logic [7:0] RegFlagReset  = 8'h71;

  typedef struct packed {
    logic [7:0]            heading_byte;
    logic [7:0]            data_flag_byte;
    logic [7:0]            register_flag_byte;
    logic [8*NumSlots-1:0] accepted_codes;
    logic [NumSlots-1:0]   code_slot_enable;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  parse_state;
    logic        word_valid;
    logic [5:0]  word_index;
    logic [15:0] word_value;
    logic        packet_kind;
    logic [7:0]  register_code;
    logic        last_word;
  } result_t;

endpackage

/* design/sensor_frame_parser_top.sv */
// ----------------------------------------------------------------------------
// sensor_frame_parser_top
// frames sensor packets from a byte stream and emits their payload words
// ----------------------------------------------------------------------------
// usage:
//  - slave stream: one item per handshake; tdata carries the received symbol,
//    tuser the command (0 feeds the symbol, 1 restarts the parser)
//  - master stream: exactly one result word per accepted input word; tdata holds
//    the state after the symbol and the completed payload word if any, tuser the
//    frame kind, tlast marks the word that ends a frame
//  - apb port: heading, flag bytes, seven accepted register codes and their
//    slot enables, 64-bit registers at byte addresses 8*i; write only while idle
//  - a taken result is registered into the output register, or into the skid
//    register while the receiver stalls; throughput is one word per cycle
//    while s_axis_tready is high, set by the single state update per symbol
//  - a two-entry output stage (result register plus skid register) keeps
//    s_axis_tready high after the receiver stalls until the skid entry fills;
//    it drops only while both entries are full
//  - reset: parser in start state, all counters zero, registers at defaults,
//    output stage empty
// ----------------------------------------------------------------------------
module sensor_frame_parser_top
  import sfp_pkg::*;
#(
  parameter int unsigned DATA_WORDS     = 9,
  parameter int unsigned REGISTER_WORDS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // symbol[8:0], zero fill [15:9]
  input  logic        s_axis_tuser,   // cmd
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // parse_state[3:0], word_valid[4], word_index[10:5],
                                      // word_value[26:11], register_code[34:27], zero [39:35]
  output logic        m_axis_tuser,   // packet_kind
  output logic        m_axis_tlast,   // last_word
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  result_t    res_new;
  result_t    out_q, skid_q;
  logic       out_vld_q, skid_vld_q;
  logic       take;

  // ---------------- configuration registers ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heading_byte       <= HeadingReset;
      cfg_q.data_flag_byte     <= DataFlagReset;
      cfg_q.register_flag_byte <= RegFlagReset;
      cfg_q.accepted_codes     <= '0;
      cfg_q.code_slot_enable   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegHeading:  cfg_q.heading_byte       <= pwdata[7:0];
        RegDataFlag: cfg_q.data_flag_byte     <= pwdata[7:0];
        RegRegFlag:  cfg_q.register_flag_byte <= pwdata[7:0];
        RegCodes:    cfg_q.accepted_codes     <= pwdata[8*NumSlots-1:0];
        RegSlotEn:   cfg_q.code_slot_enable   <= pwdata[NumSlots-1:0];
        default:     ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (reg_idx)
      RegHeading:  prdata = {56'h0, cfg_q.heading_byte};
      RegDataFlag: prdata = {56'h0, cfg_q.data_flag_byte};
      RegRegFlag:  prdata = {56'h0, cfg_q.register_flag_byte};
      RegCodes:    prdata = {8'h0, cfg_q.accepted_codes};
      RegSlotEn:   prdata = {57'h0, cfg_q.code_slot_enable};
      default:     prdata = '0;
    endcase
  end

  // ---------------- parser ----------------
  // a word is taken whenever the skid entry is free
  assign s_axis_tready = !skid_vld_q;
  assign take          = s_axis_tvalid && s_axis_tready;

  sfp_core #(
    .DATA_WORDS     (DATA_WORDS),
    .REGISTER_WORDS (REGISTER_WORDS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .take_i   (take),
    .cmd_i    (s_axis_tuser),
    .symbol_i (s_axis_tdata[8:0]),
    .res_o    (res_new)
  );

  // ---------------- output stage with skid ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      // output slot frees up: drain skid first, else take the new result
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= take;
      end
    end else if (take) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready) begin
      out_q <= skid_vld_q ? skid_q : res_new;
    end else if (take) begin
      skid_q <= res_new;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'h0, out_q.register_code, out_q.word_value, out_q.word_index,
                          out_q.word_valid, out_q.parse_state};
  assign m_axis_tuser  = out_q.packet_kind;
  assign m_axis_tlast  = out_q.last_word;

endmodule

/* design/sfp_core.sv */
// ----------------------------------------------------------------------------
// sfp_core
// frame state machine: one symbol per accepted word, result formed in the same cycle
// ----------------------------------------------------------------------------
module sfp_core
  import sfp_pkg::*;
#(
  parameter int unsigned DATA_WORDS     = 9,
  parameter int unsigned REGISTER_WORDS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       take_i,
  input  logic       cmd_i,
  input  logic [8:0] symbol_i,
  output result_t    res_o
);

  typedef enum logic [3:0] {
    StStart    = 4'd0,
    StHunt     = 4'd1,
    StFlag     = 4'd2,
    StRegLow   = 4'd3,
    StRegHigh  = 4'd4,
    StDataLow  = 4'd5,
    StDataHigh = 4'd6,
    StFinal    = 4'd7,
    StError    = 4'd8
  } state_e;

  state_e      state_q, state_d;
  logic [7:0]  low_byte_q, low_byte_d;
  logic [6:0]  words_left_q, words_left_d;
  logic [5:0]  next_index_q, next_index_d;
  logic        frame_kind_q, frame_kind_d;
  logic [7:0]  code_q, code_d;

  logic [7:0]  b;
  logic        code_ok;
  logic        vld, last;
  logic [5:0]  idx;
  logic [15:0] val;

  assign b = symbol_i[7:0];

  // match against every enabled code slot
  always_comb begin
    code_ok = 1'b0;
    for (int k = 0; k < NumSlots; k++) begin
      if (cfg_i.code_slot_enable[k] && (cfg_i.accepted_codes[8*k +: 8] == b)) begin
        code_ok = 1'b1;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    low_byte_d   = low_byte_q;
    words_left_d = words_left_q;
    next_index_d = next_index_q;
    frame_kind_d = frame_kind_q;
    code_d       = code_q;
    vld          = 1'b0;
    last         = 1'b0;
    idx          = '0;
    val          = '0;
    priority if (cmd_i) begin
      state_d = StStart;
    end else if (symbol_i[8]) begin
      state_d = StError;
    end else begin
      unique case (state_q)
        StStart, StHunt: begin
          state_d = (b == cfg_i.heading_byte) ? StFlag : StHunt;
        end
        StFlag: begin
          priority if (b == cfg_i.data_flag_byte) begin
            frame_kind_d = 1'b0;
            next_index_d = '0;
            words_left_d = 7'(DATA_WORDS);
            state_d      = StDataLow;
          end else if (b == cfg_i.register_flag_byte) begin
            frame_kind_d = 1'b1;
            state_d      = StRegLow;
          end else if (b == cfg_i.heading_byte) begin
            state_d = StFlag;
          end else begin
            state_d = StHunt;
          end
        end
        StRegLow: begin
          priority if (code_ok) begin
            low_byte_d = b;
            state_d    = StRegHigh;
          end else if (b == cfg_i.heading_byte) begin
            state_d = StFlag;
          end else begin
            state_d = StHunt;
          end
        end
        StRegHigh: begin
          priority if (b == 8'h00) begin
            code_d       = low_byte_q;
            next_index_d = '0;
            words_left_d = 7'(REGISTER_WORDS);
            state_d      = StDataLow;
          end else if (b == cfg_i.heading_byte) begin
            state_d = StFlag;
          end else begin
            state_d = StHunt;
          end
        end
        StDataLow: begin
          low_byte_d = b;
          state_d    = StDataHigh;
        end
        StDataHigh: begin
          vld          = 1'b1;
          idx          = next_index_q;
          val          = {b, low_byte_q};
          next_index_d = next_index_q + 6'd1;
          if (words_left_q <= 7'd1) begin
            words_left_d = '0;
            last         = 1'b1;
            state_d      = StFinal;
          end else begin
            words_left_d = words_left_q - 7'd1;
            state_d      = StDataLow;
          end
        end
        StFinal, StError: begin
          state_d = state_q;
        end
        default: begin
          state_d = StError;
        end
      endcase
    end
  end

  always_comb begin
    res_o.parse_state   = state_d;
    res_o.word_valid    = vld;
    res_o.word_index    = idx;
    res_o.word_value    = val;
    res_o.packet_kind   = frame_kind_d;
    res_o.register_code = frame_kind_d ? code_d : 8'h00;
    res_o.last_word     = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StStart;
      low_byte_q   <= '0;
      words_left_q <= '0;
      next_index_q <= '0;
      frame_kind_q <= 1'b0;
      code_q       <= '0;
    end else if (take_i) begin
      state_q      <= state_d;
      low_byte_q   <= low_byte_d;
      words_left_q <= words_left_d;
      next_index_q <= next_index_d;
      frame_kind_q <= frame_kind_d;
      code_q       <= code_d;
    end
  end

endmodule
